[rtl/mte_pkg.sv]
package mte_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned ENC_BITS_DEF = 16;

  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 32;

  localparam logic [CODE_W-1:0] ENCODER_CODE = 8'h31;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FIRST    = 3'd1,
    ST_BAD_ADDR = 3'd2,
    ST_NO_REPLY = 3'd3,
    ST_BAD_CODE = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

[rtl/mte_req_if.sv]
interface mte_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [mte_pkg::ADDR_W-1:0]     motor_address;
  logic                           reply_arrived;
  logic [mte_pkg::CODE_W-1:0]     reply_code;
  logic [mte_pkg::RAW_W-1:0]      raw_position;

  modport source (output valid, operation, motor_address, reply_arrived, reply_code,
                  raw_position, input ready);
  modport sink   (input valid, operation, motor_address, reply_arrived, reply_code,
                  raw_position, output ready);
endinterface

[rtl/mte_rsp_if.sv]
interface mte_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mte_pkg::STATUS_W-1:0]   status;
  logic signed [mte_pkg::POS_W-1:0] position;

  modport source (output valid, status, position, input ready);
  modport sink   (input valid, status, position, output ready);
endinterface

[rtl/mte_ctrl.sv]
module mte_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mte_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = slot_free;
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("controller state not one-hot");

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_EXEC) else $error("capture did not lead to exec");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r) else $error("execute without result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && out_valid_r && !out_ready |=> state_r == S_EXEC)
    else $error("pending result overwritten");

endmodule

[rtl/mte_dp.sv]
module mte_dp #(
  parameter int unsigned Channels = mte_pkg::CHANNELS_DEF,
  parameter int unsigned EncBits  = mte_pkg::ENC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mte_pkg::dp_cmd_t                   cmd,
  input  logic                               in_operation,
  input  logic [mte_pkg::ADDR_W-1:0]         in_motor_address,
  input  logic                               in_reply_arrived,
  input  logic [mte_pkg::CODE_W-1:0]         in_reply_code,
  input  logic [mte_pkg::RAW_W-1:0]          in_raw_position,
  output logic [mte_pkg::STATUS_W-1:0]       out_status,
  output logic signed [mte_pkg::POS_W-1:0]   out_position
);

  localparam int unsigned ChW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned PosW = mte_pkg::POS_W;
  localparam logic signed [EncBits+1:0] HalfTurn = (EncBits+2)'(64'(1) << (EncBits - 1));
  localparam logic signed [EncBits+1:0] TurnCnt  = (EncBits+2)'(64'(1) << EncBits);

  // captured request
  logic                         op_r;
  logic [mte_pkg::ADDR_W-1:0]   addr_r;
  logic                         arrived_r;
  logic [mte_pkg::CODE_W-1:0]   code_r;
  logic [EncBits-1:0]           raw_r;

  // per-channel state
  logic [EncBits-1:0] prev_r    [Channels];
  logic [EncBits-1:0] prev_nxt  [Channels];
  logic [PosW-1:0]    acc_r     [Channels];
  logic [PosW-1:0]    acc_nxt   [Channels];
  logic [Channels-1:0] started_r, started_nxt;

  logic [mte_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [PosW-1:0]              pos_r, pos_nxt;

  logic                         addr_ok;
  logic [ChW-1:0]               ch;
  logic [EncBits-1:0]           prev_sel;
  logic [PosW-1:0]              acc_sel;
  logic signed [EncBits:0]      diff;
  logic signed [EncBits+1:0]    diff_ext;
  logic signed [EncBits+1:0]    corr;
  logic signed [PosW-1:0]       corr_ext;
  logic [PosW-1:0]              sum;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_operation;
      addr_r    <= in_motor_address;
      arrived_r <= in_reply_arrived;
      code_r    <= in_reply_code;
      raw_r     <= EncBits'(in_raw_position);
    end
  end

  assign addr_ok  = (addr_r != '0) && ({1'b0, addr_r} <= 9'(Channels));
  assign ch       = ChW'(addr_r - 8'd1);
  assign prev_sel = prev_r[ch];
  assign acc_sel  = acc_r[ch];

  assign diff     = $signed({1'b0, raw_r}) - $signed({1'b0, prev_sel});
  assign diff_ext = (EncBits+2)'(diff);
  assign corr     = (diff_ext > HalfTurn)  ? diff_ext - TurnCnt :
                    (diff_ext < -HalfTurn) ? diff_ext + TurnCnt : diff_ext;
  assign corr_ext = PosW'(corr);
  assign sum      = acc_sel + corr_ext;

  always_comb begin
    prev_nxt    = prev_r;
    acc_nxt     = acc_r;
    started_nxt = started_r;
    status_nxt  = mte_pkg::ST_OK;
    pos_nxt     = '0;
    if (op_r == mte_pkg::OP_CLEAR) begin
      if (addr_r == '0) begin
        for (int i = 0; i < Channels; i++) begin
          acc_nxt[i] = '0;
        end
      end else if (addr_ok) begin
        acc_nxt[ch] = '0;
      end else begin
        status_nxt = mte_pkg::ST_BAD_ADDR;
      end
    end else begin
      priority if (!addr_ok) begin
        status_nxt = mte_pkg::ST_BAD_ADDR;
      end else if (!arrived_r) begin
        status_nxt = mte_pkg::ST_NO_REPLY;
      end else if (code_r != mte_pkg::ENCODER_CODE) begin
        status_nxt = mte_pkg::ST_BAD_CODE;
      end else if (!started_r[ch]) begin
        prev_nxt[ch]    = raw_r;
        acc_nxt[ch]     = '0;
        started_nxt[ch] = 1'b1;
        status_nxt      = mte_pkg::ST_FIRST;
      end else begin
        prev_nxt[ch] = raw_r;
        acc_nxt[ch]  = sum;
        pos_nxt      = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Channels; i++) begin
        prev_r[i] <= '0;
        acc_r[i]  <= '0;
      end
      started_r <= '0;
    end else if (cmd.execute) begin
      prev_r    <= prev_nxt;
      acc_r     <= acc_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_status   = status_r;
  assign out_position = $signed(pos_r);

endmodule

[rtl/multiturn_encoder_unwrap.sv]
// Multi-turn position tracker for up to Channels motors fed by single-turn encoder replies.
// Each request is either a sample (address 1..Channels, reply flag, reply code, raw reading)
// or a clear (one channel, or all channels for address 0) and yields exactly one response
// with a status and a 32-bit wrapping position. A request is captured in the idle state and
// executed in the execute state; no new request is taken until it is executed. The execute
// step waits only while the previous response is still held unread in the output register.
// Channel state lives in flip-flops and is zeroed by reset.
module multiturn_encoder_unwrap #(
  parameter int unsigned CHANNELS     = mte_pkg::CHANNELS_DEF,
  parameter int unsigned ENCODER_BITS = mte_pkg::ENC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mte_req_if.sink    in_req,
  mte_rsp_if.source  out_rsp
);

  mte_pkg::dp_cmd_t cmd;

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  mte_dp #(
    .Channels (CHANNELS),
    .EncBits  (ENCODER_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_req.operation),
    .in_motor_address (in_req.motor_address),
    .in_reply_arrived (in_req.reply_arrived),
    .in_reply_code    (in_req.reply_code),
    .in_raw_position  (in_req.raw_position),
    .out_status       (out_rsp.status),
    .out_position     (out_rsp.position)
  );

endmodule

[test/multiturn_encoder_unwrap_test.sv]
module multiturn_encoder_unwrap_test;

  localparam int unsigned CHANNELS = mte_pkg::CHANNELS_DEF;
  localparam int unsigned ADDR_W = mte_pkg::ADDR_W;
  localparam int unsigned CODE_W = mte_pkg::CODE_W;
  localparam int unsigned RAW_W = mte_pkg::RAW_W;
  localparam int unsigned POS_W = mte_pkg::POS_W;
  localparam int TURN = 1 << mte_pkg::ENC_BITS_DEF;
  localparam int HALF = TURN / 2;
  localparam int RANDOM_REQUESTS = 1750;
  localparam int HOLD_AT = 600;
  localparam int PAUSE_AT = 1200;
  localparam int LONG_HOLD = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP = 50;
  localparam logic FIXED = 1'b1;
  localparam logic PREDICT = 1'b0;
  localparam mte_pkg::op_t SAMPLE = mte_pkg::OP_SAMPLE;
  localparam mte_pkg::op_t CLEAR = mte_pkg::OP_CLEAR;
  localparam logic [CODE_W-1:0] ENC_CODE = mte_pkg::ENCODER_CODE;

  typedef struct packed {
    mte_pkg::op_t        operation;
    logic [ADDR_W-1:0]   motor_address;
    logic                reply_arrived;
    logic [CODE_W-1:0]   reply_code;
    logic [RAW_W-1:0]    raw_position;
  } request_t;

  typedef struct packed {
    mte_pkg::status_t         status;
    logic signed [POS_W-1:0]  position;
  } reply_t;

  typedef struct packed {
    request_t                 req;
    logic                     fixed;
    mte_pkg::status_t         status;
    logic signed [POS_W-1:0]  position;
  } directed_row_t;

  // fixed rows carry their reply; the rest go through the tracker
  localparam directed_row_t DIRECTED_ROWS [0:22] = '{
    '{'{SAMPLE, 8'd0,  1'b1, ENC_CODE, 16'h0000}, FIXED,   mte_pkg::ST_BAD_ADDR, 32'sd0},
    '{'{SAMPLE, 8'd9,  1'b1, ENC_CODE, 16'hFFFF}, FIXED,   mte_pkg::ST_BAD_ADDR, 32'sd0},
    '{'{SAMPLE, 8'hFF, 1'b0, 8'h00,    16'h0000}, FIXED,   mte_pkg::ST_BAD_ADDR, 32'sd0},
    '{'{SAMPLE, 8'd1,  1'b0, 8'h00,    16'h1234}, FIXED,   mte_pkg::ST_NO_REPLY, 32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, 8'h30,    16'h1234}, FIXED,   mte_pkg::ST_BAD_CODE, 32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, 8'hFF,    16'h1234}, FIXED,   mte_pkg::ST_BAD_CODE, 32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, ENC_CODE, 16'hFFFF}, FIXED,   mte_pkg::ST_FIRST,    32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, ENC_CODE, 16'h0000}, PREDICT, mte_pkg::ST_OK,       32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, ENC_CODE, 16'h8000}, PREDICT, mte_pkg::ST_OK,       32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, ENC_CODE, 16'h0000}, PREDICT, mte_pkg::ST_OK,       32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, ENC_CODE, 16'h8001}, PREDICT, mte_pkg::ST_OK,       32'sd0},
    '{'{SAMPLE, 8'd8,  1'b1, ENC_CODE, 16'h1234}, FIXED,   mte_pkg::ST_FIRST,    32'sd0},
    '{'{SAMPLE, 8'd8,  1'b1, ENC_CODE, 16'h1234}, FIXED,   mte_pkg::ST_OK,       32'sd0},
    '{'{CLEAR,  8'd1,  1'b0, 8'h00,    16'h0000}, FIXED,   mte_pkg::ST_OK,       32'sd0},
    '{'{SAMPLE, 8'd1,  1'b1, ENC_CODE, 16'h8001}, PREDICT, mte_pkg::ST_OK,       32'sd0},
    '{'{SAMPLE, 8'd8,  1'b1, ENC_CODE, 16'h9234}, PREDICT, mte_pkg::ST_OK,       32'sd0},
    '{'{CLEAR,  8'd0,  1'b1, ENC_CODE, 16'hFFFF}, FIXED,   mte_pkg::ST_OK,       32'sd0},
    '{'{CLEAR,  8'd9,  1'b1, ENC_CODE, 16'h0000}, FIXED,   mte_pkg::ST_BAD_ADDR, 32'sd0},
    '{'{CLEAR,  8'hFF, 1'b1, ENC_CODE, 16'hFFFF}, FIXED,   mte_pkg::ST_BAD_ADDR, 32'sd0},
    '{'{SAMPLE, 8'd8,  1'b1, ENC_CODE, 16'h9234}, PREDICT, mte_pkg::ST_OK,       32'sd0},
    '{'{CLEAR,  8'd8,  1'b0, 8'hAA,    16'h5555}, FIXED,   mte_pkg::ST_OK,       32'sd0},
    '{'{SAMPLE, 8'd2,  1'b1, ENC_CODE, 16'h0000}, FIXED,   mte_pkg::ST_FIRST,    32'sd0},
    '{'{SAMPLE, 8'd2,  1'b1, ENC_CODE, 16'h7FFF}, PREDICT, mte_pkg::ST_OK,       32'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mte_req_if req_ch ();
  mte_rsp_if rsp_ch ();

  multiturn_encoder_unwrap u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_rsp (rsp_ch.source)
  );

  always #5 clk = ~clk;

  logic [RAW_W-1:0]        last_reading [CHANNELS];
  logic signed [POS_W-1:0] turn_count   [CHANNELS];
  bit                      started      [CHANNELS];

  reply_t replies_due [$];
  int     mismatches = 0;
  int     positions_seen = 0;
  int     starts_seen = 0;
  int     rejects_seen = 0;
  int     clears_sent = 0;
  bit     hold_rsp = 1'b0;
  bit     send_burst = 1'b0;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int unsigned idle_draw(bit burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic reply_t track_position(request_t r);
    reply_t      res;
    bit          in_range;
    int unsigned slot;
    int          now_val;
    int          was_val;
    int          delta_pos;
    res.status = mte_pkg::ST_OK;
    res.position = '0;
    in_range = (r.motor_address >= 1) && (r.motor_address <= CHANNELS);
    slot = in_range ? r.motor_address - 1 : 0;
    if (r.operation == mte_pkg::OP_CLEAR) begin
      if (r.motor_address == 0) begin
        foreach (turn_count[i]) turn_count[i] = '0;
      end else if (in_range) begin
        turn_count[slot] = '0;
      end else begin
        res.status = mte_pkg::ST_BAD_ADDR;
      end
    end else if (!in_range) begin
      res.status = mte_pkg::ST_BAD_ADDR;
    end else if (!r.reply_arrived) begin
      res.status = mte_pkg::ST_NO_REPLY;
    end else if (r.reply_code != mte_pkg::ENCODER_CODE) begin
      res.status = mte_pkg::ST_BAD_CODE;
    end else if (!started[slot]) begin
      last_reading[slot] = r.raw_position;
      turn_count[slot] = '0;
      started[slot] = 1'b1;
      res.status = mte_pkg::ST_FIRST;
    end else begin
      now_val = r.raw_position;
      was_val = last_reading[slot];
      delta_pos = now_val - was_val;
      // shorter way round; exactly half a turn stands as is
      if (delta_pos > HALF) delta_pos -= TURN;
      else if (delta_pos < -HALF) delta_pos += TURN;
      turn_count[slot] = turn_count[slot] + delta_pos;
      last_reading[slot] = r.raw_position;
      res.position = turn_count[slot];
    end
    return res;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned slot;
    int          delta;
    pick = $urandom_range(0, 99);
    r.operation = mte_pkg::OP_SAMPLE;
    r.motor_address = ADDR_W'($urandom_range(1, CHANNELS));
    r.reply_arrived = 1'b1;
    r.reply_code = mte_pkg::ENCODER_CODE;
    r.raw_position = RAW_W'($urandom);
    slot = r.motor_address - 1;
    if (pick < 72) begin
      case ($urandom_range(0, 4))
        0: delta = int'($urandom_range(0, 64)) - 32;
        1: delta = int'($urandom_range(0, 2000)) - 1000;
        2: delta = HALF + int'($urandom_range(0, 4)) - 2;
        3: delta = -HALF + int'($urandom_range(0, 4)) - 2;
        default: delta = $urandom;
      endcase
      if (started[slot]) r.raw_position = last_reading[slot] + RAW_W'(delta);
    end else if (pick < 78) begin
      r.operation = mte_pkg::OP_CLEAR;
      r.motor_address = ADDR_W'($urandom_range(0, CHANNELS + 2));
      r.reply_arrived = 1'($urandom_range(0, 1));
      r.reply_code = CODE_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: r.motor_address = ADDR_W'($urandom);
        1: r.reply_arrived = 1'b0;
        2: r.reply_code = CODE_W'($urandom);
        default: begin
          r.operation = mte_pkg::op_t'($urandom_range(0, 1));
          r.motor_address = ADDR_W'($urandom);
          r.reply_arrived = 1'($urandom_range(0, 1));
          r.reply_code = CODE_W'($urandom);
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_request(request_t r, int unsigned gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= r.operation;
    req_ch.motor_address <= r.motor_address;
    req_ch.reply_arrived <= r.reply_arrived;
    req_ch.reply_code    <= r.reply_code;
    req_ch.raw_position  <= r.raw_position;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (r.operation == mte_pkg::OP_CLEAR) clears_sent++;
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // receiver
  initial begin
    reply_t      want;
    int unsigned gap;
    int          taken;
    bit          rsp_burst;
    taken = 0;
    rsp_burst = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rsp = 1'b0;
      end
      if (taken % 80 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      gap = idle_draw(rsp_burst);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      taken++;
      case (rsp_ch.status)
        mte_pkg::ST_OK:    positions_seen++;
        mte_pkg::ST_FIRST: starts_seen++;
        default:           rejects_seen++;
      endcase
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected reply status %0d position %0d",
                                  rsp_ch.status, rsp_ch.position));
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    rsp_ch.status, want.status));
        if (rsp_ch.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    rsp_ch.position, want.position));
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall = 0;
      else stall++;
    end
    $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // sender and sequencing
  initial begin
    request_t r;
    reply_t   want;
    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= mte_pkg::OP_SAMPLE;
    req_ch.motor_address <= '0;
    req_ch.reply_arrived <= 1'b0;
    req_ch.reply_code    <= '0;
    req_ch.raw_position  <= '0;
    foreach (started[i]) begin
      started[i] = 1'b0;
      last_reading[i] = '0;
      turn_count[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[k]) begin
      r = DIRECTED_ROWS[k].req;
      send_request(r, idle_draw(1'b0));
      want = track_position(r);
      if (DIRECTED_ROWS[k].fixed) begin
        want.status = DIRECTED_ROWS[k].status;
        want.position = DIRECTED_ROWS[k].position;
      end
      replies_due.push_back(want);
    end
    wait_idle();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      // receiver stalls while requests keep coming, so the block backs up
      if (n == HOLD_AT) begin
        hold_rsp = 1'b1;
        send_burst = 1'b1;
      end
      if (n == PAUSE_AT) wait_idle();
      r = random_request();
      send_request(r, idle_draw(send_burst));
      replies_due.push_back(track_position(r));
    end
    req_ch.valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d directed and %0d random requests, %0d of them clears, incl. a long output stall",
             $size(DIRECTED_ROWS), RANDOM_REQUESTS, clears_sent);
    $display("replies: %0d positions, %0d channel starts, %0d rejects, %0d mismatches",
             positions_seen, starts_seen, rejects_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
